// ===== rtl/sops_pkg.sv =====
package sops_pkg;

   // Segment and table geometry.
   localparam int SEGMENT_BYTES = 32760;
   localparam int PRIMES_MAX    = 4096;
   localparam int SEG_BITS      = SEGMENT_BYTES * 8;
   localparam int SEG_WORDS     = (SEGMENT_BYTES + 7) / 8;
   localparam int LAST_BYTES    = SEGMENT_BYTES - 8 * (SEG_WORDS - 1);
   localparam int WORD_AW       = (SEG_WORDS > 1) ? $clog2(SEG_WORDS) : 1;
   localparam int PRIME_AW      = (PRIMES_MAX > 1) ? $clog2(PRIMES_MAX) : 1;
   localparam int STRIKE_W      = 33;
   localparam int COUNT_W       = 13;

   // Byte pattern that removes multiples of 3, and the first byte at cursor zero.
   localparam logic [7:0] THREE_PATTERN [3] = '{8'h6D, 8'hDB, 8'hB6};
   localparam logic [7:0] CURSOR0_BYTE0 = 8'h6E;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_SIEVE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_BAD   = 2'd3
   } func_type;

   typedef enum logic {
      CSR_START_CURSOR = 1'b0,
      CSR_PRIME_COUNT  = 1'b1
   } csr_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic req_load;
      logic load_sq;
      logic load_cmp;
      logic div_start;
      logic div_take;
      logic load_wr;
      logic fill_wr;
      logic scan_init;
      logic scan_rd;
      logic strike_init;
      logic scan_next;
      logic strike_rd;
      logic strike_wr;
      logic save;
      logic word_rd;
      logic resp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_done;
      logic div_busy;
      logic fill_last;
      logic cnt_zero;
      logic scan_last;
      logic hit;
      logic strike_end;
   } sts_type;

   // One 64-bit word of the pattern, starting at the given byte phase.
   function automatic logic [63:0] pattern_word(input logic [1:0] phase);
      logic [63:0] w;
      logic [1:0]  ph;
      w  = '0;
      ph = phase;
      for (int k = 0; k < 8; k++) begin
         w[8*k +: 8] = THREE_PATTERN[ph];
         ph = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
      end
      return w;
   endfunction

   // Bytes of the last word that lie inside the segment.
   function automatic logic [63:0] last_mask();
      logic [63:0] m;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         if (k < LAST_BYTES) begin
            m[8*k +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

// ===== rtl/sops_div.sv =====
module sops_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [31:0] remainder
);
   import sops_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [32:0] trial;

   // Restoring division, one quotient bit per cycle; only the remainder is kept.
   always_comb begin
      trial   = {rem_ff, num_ff[63]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? 32'(trial - {1'b0, divisor}) : trial[31:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/sops_ctrl.sv =====
module sops_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_func,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  sops_pkg::sts_type sts,
   output sops_pkg::cmd_type cmd
);
   import sops_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_SQUARE = 13'b0000000000010,
      ST_CMP    = 13'b0000000000100,
      ST_DIV    = 13'b0000000001000,
      ST_LWR    = 13'b0000000010000,
      ST_FILL   = 13'b0000000100000,
      ST_SRD    = 13'b0000001000000,
      ST_SCHK   = 13'b0000010000000,
      ST_BRD    = 13'b0000100000000,
      ST_BWR    = 13'b0001000000000,
      ST_SAVE   = 13'b0010000000000,
      ST_WRD    = 13'b0100000000000,
      ST_RESP   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer for loads, segment sieving, word reads and unknown functions.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               unique case (func_type'(req_func))
                  FUNC_LOAD:  state_in = ST_SQUARE;
                  FUNC_SIEVE: state_in = ST_FILL;
                  FUNC_READ:  state_in = ST_WRD;
                  FUNC_BAD:   state_in = ST_RESP;
               endcase
            end
         end
         ST_SQUARE: begin
            cmd.load_sq = 1'b1;
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            cmd.load_cmp = 1'b1;
            if (sts.need_div && !sts.div_busy) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_LWR;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_LWR;
            end
         end
         ST_LWR: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_RESP;
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) begin
               cmd.scan_init = 1'b1;
               state_in      = sts.cnt_zero ? ST_RESP : ST_SRD;
            end
         end
         ST_SRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCHK;
         end
         ST_SCHK: begin
            if (sts.hit) begin
               cmd.strike_init = 1'b1;
               state_in        = ST_BRD;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = sts.scan_last ? ST_RESP : ST_SRD;
            end
         end
         ST_BRD: begin
            cmd.strike_rd = 1'b1;
            state_in      = ST_BWR;
         end
         ST_BWR: begin
            cmd.strike_wr = 1'b1;
            state_in      = sts.strike_end ? ST_SAVE : ST_BRD;
         end
         ST_SAVE: begin
            cmd.save      = 1'b1;
            cmd.scan_next = 1'b1;
            state_in      = sts.scan_last ? ST_RESP : ST_SRD;
         end
         ST_WRD: begin
            cmd.word_rd = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) begin
               cmd.resp_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: holds a result until its transfer completes.
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || cmd.resp_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_dual_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_wr && cmd.strike_wr))
      else $error("fill and strike write the bitmap together");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> sts.div_busy)
      else $error("divider did not start");

   a_resp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrites a pending transfer");

endmodule

// ===== rtl/sops_dpath.sv =====
module sops_dpath (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_func,
   input  logic [11:0]       req_prime_index,
   input  logic [31:0]       req_prime_value,
   input  logic [11:0]       req_word_index,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [62:0]       csr_data,
   input  sops_pkg::cmd_type cmd,
   output sops_pkg::sts_type sts,
   output logic              rsp_status,
   output logic [62:0]       rsp_segment_base,
   output logic [63:0]       rsp_word_data
);
   import sops_pkg::*;

   logic [63:0] bitmap [SEG_WORDS];
   logic [31:0] base_prime [PRIMES_MAX];
   logic [63:0] next_strike [PRIMES_MAX];

   logic [1:0]          func_ff;
   logic [11:0]         idx_ff, word_ff;
   logic [31:0]         val_ff;
   logic [63:0]         square_ff, strike_ff;
   logic [WORD_AW-1:0]  w_ff;
   logic [1:0]          phase_ff;
   logic [COUNT_W-1:0]  i_ff;
   logic [31:0]         p_rd_ff, p_ff;
   logic [63:0]         nx_rd_ff, bm_rd_ff;
   logic [STRIKE_W-1:0] b_ff, b_next;
   logic [62:0]         cursor_ff;
   logic [COUNT_W-1:0]  count_ff, count_sat;
   logic                status_ff;
   logic [62:0]         base_ff;
   logic [63:0]         data_ff;

   logic [63:0]        cursor64, seg_end, start_val, fill_word;
   logic               slot_ok, word_ok, div_busy, div_done;
   logic [31:0]        div_rem;
   logic [WORD_AW-1:0] strike_addr, rd_addr;

   assign cursor64    = {1'b0, cursor_ff};
   assign seg_end     = cursor64 + 64'(SEG_BITS);
   assign start_val   = {1'b0, square_ff[63:1]};
   assign slot_ok     = 32'(idx_ff) < 32'(PRIMES_MAX);
   assign word_ok     = 32'(word_ff) < 32'(SEG_WORDS);
   assign count_sat   = (32'(count_ff) > 32'(PRIMES_MAX)) ? COUNT_W'(PRIMES_MAX) : count_ff;
   assign b_next      = b_ff + {1'b0, p_ff};
   assign strike_addr = WORD_AW'(b_ff >> 6);
   assign rd_addr     = cmd.strike_rd ? strike_addr : WORD_AW'(word_ff);

   // Pattern word for the current fill position.
   always_comb begin
      fill_word = pattern_word(phase_ff);
      if (w_ff == '0 && cursor_ff == '0) begin
         fill_word[7:0] = CURSOR0_BYTE0;
      end
      if (w_ff == WORD_AW'(SEG_WORDS - 1)) begin
         fill_word = fill_word & last_mask();
      end
   end

   // Status toward the controller.
   always_comb begin
      sts            = '0;
      sts.need_div   = (val_ff != '0) && (start_val < cursor64);
      sts.div_done   = div_done;
      sts.div_busy   = div_busy;
      sts.fill_last  = (w_ff == WORD_AW'(SEG_WORDS - 1));
      sts.cnt_zero   = (count_sat == '0);
      sts.scan_last  = (i_ff + COUNT_W'(1)) == count_sat;
      sts.hit        = (p_rd_ff != '0) && (nx_rd_ff >= cursor64) && (nx_rd_ff < seg_end);
      sts.strike_end = b_next >= STRIKE_W'(SEG_BITS);
   end

   sops_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (cursor64 - start_val),
      .divisor   (val_ff),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   // Configuration registers and the running cursor.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         count_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_type'(csr_index))
            CSR_START_CURSOR: cursor_ff <= csr_data;
            CSR_PRIME_COUNT:  count_ff  <= csr_data[COUNT_W-1:0];
         endcase
      end else if (cmd.resp_load && func_type'(func_ff) == FUNC_SIEVE) begin
         cursor_ff <= cursor_ff + 63'(SEG_BITS);
      end
   end

   // Working registers of the item in progress.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         func_ff  <= req_func;
         idx_ff   <= req_prime_index;
         val_ff   <= req_prime_value;
         word_ff  <= req_word_index;
         w_ff     <= '0;
         phase_ff <= 2'd0;
      end
      if (cmd.load_sq) begin
         square_ff <= val_ff * val_ff;
      end
      if (cmd.load_cmp) begin
         strike_ff <= (val_ff == '0) ? '1 : start_val;
      end
      if (cmd.div_take) begin
         strike_ff <= (div_rem == '0) ? cursor64 : cursor64 + 64'(val_ff - div_rem);
      end
      if (cmd.fill_wr) begin
         w_ff     <= w_ff + WORD_AW'(1);
         phase_ff <= (phase_ff == 2'd0) ? 2'd2 : phase_ff - 2'd1;
      end
      if (cmd.scan_init) begin
         i_ff <= '0;
      end else if (cmd.scan_next) begin
         i_ff <= i_ff + COUNT_W'(1);
      end
      if (cmd.strike_init) begin
         b_ff <= STRIKE_W'(nx_rd_ff - cursor64);
         p_ff <= p_rd_ff;
      end else if (cmd.strike_wr) begin
         b_ff <= b_next;
      end
   end

   // Segment bitmap: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.fill_wr) begin
         bitmap[w_ff] <= fill_word;
      end else if (cmd.strike_wr) begin
         bitmap[strike_addr] <= bm_rd_ff & ~(64'd1 << b_ff[5:0]);
      end
      if (cmd.strike_rd || (cmd.word_rd && word_ok)) begin
         bm_rd_ff <= bitmap[rd_addr];
      end
   end

   // Prime table: base value and next strike position.
   always_ff @(posedge clock) begin
      if (cmd.load_wr && slot_ok) begin
         base_prime[PRIME_AW'(idx_ff)]  <= val_ff;
         next_strike[PRIME_AW'(idx_ff)] <= strike_ff;
      end else if (cmd.save) begin
         next_strike[i_ff[PRIME_AW-1:0]] <= cursor64 + 64'(b_ff);
      end
      if (cmd.scan_rd) begin
         p_rd_ff  <= base_prime[i_ff[PRIME_AW-1:0]];
         nx_rd_ff <= next_strike[i_ff[PRIME_AW-1:0]];
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         base_ff <= cursor_ff;
         data_ff <= '0;
         unique case (func_type'(func_ff))
            FUNC_LOAD:  status_ff <= !slot_ok;
            FUNC_SIEVE: status_ff <= 1'b0;
            FUNC_READ: begin
               status_ff <= !word_ok;
               data_ff   <= word_ok ? bm_rd_ff : '0;
            end
            FUNC_BAD:   status_ff <= 1'b1;
         endcase
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_segment_base = base_ff;
   assign rsp_word_data    = data_ff;

endmodule

// ===== rtl/segmented_odd_prime_sieve.sv =====
// Load: squares the prime and compares, and runs the remainder unit when the first strike
//    lies below the cursor. Sieve: fills the bitmap word by word, then scans each prime and
//    strikes its multiples in the segment with a bitmap read and a bitmap write per strike.
// Read: returns one bitmap word. One item at a time; results wait in an output register.
// Reset clears the cursor, the prime count and the handshake state; memories are not cleared.
module segmented_odd_prime_sieve (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [11:0] req_prime_index,
   input  logic [31:0] req_prime_value,
   input  logic [11:0] req_word_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [62:0] rsp_segment_base,
   output logic [63:0] rsp_word_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [62:0] csr_data
);
   import sops_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   sops_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sops_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_func         (req_func),
      .req_prime_index  (req_prime_index),
      .req_prime_value  (req_prime_value),
      .req_word_index   (req_word_index),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_status       (rsp_status),
      .rsp_segment_base (rsp_segment_base),
      .rsp_word_data    (rsp_word_data)
   );

endmodule

// ===== tb/tb_segmented_odd_prime_sieve.sv =====
`timescale 1ns / 100ps

module tb_segmented_odd_prime_sieve;
   import sops_pkg::*;

   localparam int          LIMIT_CYCLES = 3000000;
   localparam logic [63:0] SEG_SPAN     = 64'(SEG_BITS);

   typedef struct {
      logic        status;
      logic [62:0] base;
      logic [63:0] data;
   } sieve_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [11:0] req_prime_index;
   logic [31:0] req_prime_value;
   logic [11:0] req_word_index;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_status;
   logic [62:0] rsp_segment_base;
   logic [63:0] rsp_word_data;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [62:0] csr_data;

   // Predictor state: registers, cursor, prime table and bitmap.
   logic [12:0] prime_count_q;
   logic [62:0] cursor_now;
   logic [31:0] prime_tab [PRIMES_MAX];
   logic [63:0] strike_tab [PRIMES_MAX];
   logic [63:0] bitmap [SEG_WORDS];

   sieve_result_type expected_results[$];

   int cycle_count;
   int error_count;
   int items_sent;
   int sieves_sent;
   int results_checked;
   int stall_pct;
   int hold_req;
   int hold_cnt;
   int burst_cnt;
   bit gaps_on;

   segmented_odd_prime_sieve u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_prime_index  (req_prime_index),
      .req_prime_value  (req_prime_value),
      .req_word_index   (req_word_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_segment_base (rsp_segment_base),
      .rsp_word_data    (rsp_word_data),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Cycle counter with a hard limit on run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // First strike position of a prime loaded at the given cursor.
   function automatic logic [63:0] first_strike_pos(input logic [63:0] p,
                                                    input logic [63:0] cur);
      logic [63:0] sq;
      logic [63:0] k;
      sq = (p * p) >> 1;
      if (p == 0) return '1;
      if (sq < cur) begin
         k = (cur - sq + p - 1) / p;
         return sq + k * p;
      end
      return sq;
   endfunction

   // Sieve one segment at the current cursor into the predicted bitmap.
   task automatic sieve_bitmap(input logic [63:0] cur);
      int          n;
      logic [63:0] p;
      logic [63:0] nx;
      logic [63:0] b;
      for (int w = 0; w < SEG_WORDS; w++) begin
         for (int k = 0; k < 8; k++) begin
            bitmap[w][8*k +: 8] = THREE_PATTERN[(w * 8 + k) % 3];
         end
      end
      if (cur == 0) bitmap[0][7:0] = CURSOR0_BYTE0;
      n = (prime_count_q > PRIMES_MAX) ? PRIMES_MAX : int'(prime_count_q);
      for (int i = 0; i < n; i++) begin
         p  = 64'(prime_tab[i]);
         nx = strike_tab[i];
         if (p != 0 && nx >= cur && nx < cur + SEG_SPAN) begin
            b = nx - cur;
            while (b < SEG_SPAN) begin
               bitmap[b >> 6][b[5:0]] = 1'b0;
               b = b + p;
            end
            strike_tab[i] = cur + b;
         end
      end
   endtask

   // Work out the result of one accepted transfer and update the predictor.
   task automatic predict_item(input func_type f, input logic [11:0] slot,
                               input logic [31:0] value, input logic [11:0] word);
      sieve_result_type r;
      r.status = 1'b0;
      r.base   = cursor_now;
      r.data   = '0;
      case (f)
         FUNC_LOAD: begin
            prime_tab[slot]  = value;
            strike_tab[slot] = first_strike_pos(64'(value), {1'b0, cursor_now});
         end
         FUNC_SIEVE: begin
            sieve_bitmap({1'b0, cursor_now});
            cursor_now = cursor_now + 63'(SEG_BITS);
         end
         FUNC_READ: begin
            if (word < SEG_WORDS) r.data = bitmap[word];
            else r.status = 1'b1;
         end
         default: r.status = 1'b1;
      endcase
      expected_results.push_back(r);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Send one item and wait for its transfer.
   task automatic send_item(input func_type f, input logic [11:0] slot,
                            input logic [31:0] value, input logic [11:0] word);
      int gap;
      req_valid       <= 1'b1;
      req_func        <= f;
      req_prime_index <= slot;
      req_prime_value <= value;
      req_word_index  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(f, slot, value, word);
      items_sent++;
      if (f == FUNC_SIEVE) sieves_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering items and wait until every expected result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Register write; only issued while the block is idle.
   task automatic write_csr(input csr_type idx, input logic [62:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_START_CURSOR) begin
         cursor_now = value;
      end else begin
         prime_count_q = value[12:0];
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver stall: random stalls, occasional bursts and requested long holds.
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_cnt = hold_req;
         hold_req = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt = hold_cnt - 1;
      end else if (burst_cnt > 0) begin
         rsp_stall <= 1'b1;
         burst_cnt = burst_cnt - 1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < 2) begin
         burst_cnt = $urandom_range(10, 40);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      sieve_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d base=%h data=%h", $time,
                     rsp_status, rsp_segment_base, rsp_word_data);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            results_checked++;
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               error_count++;
            end
            if (rsp_segment_base !== e.base) begin
               $display("%0t: segment_base expected %h actual %h", $time, e.base,
                        rsp_segment_base);
               error_count++;
            end
            if (rsp_word_data !== e.data) begin
               $display("%0t: word_data expected %h actual %h", $time, e.data,
                        rsp_word_data);
               error_count++;
            end
         end
      end
   end

   // Unknown function, an out-of-range read and a zero-prime load before any sieve.
   task automatic test_bad_items();
      send_item(FUNC_BAD, 12'hFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_item(FUNC_READ, 12'h000, 32'h0, 12'hFFF);
      send_item(FUNC_LOAD, 12'd5, 32'h0, 12'h0);
      drain();
   endtask

   // Fill the scanned slots with zero primes and sieve at cursor zero.
   task automatic test_table_fill();
      write_csr(CSR_START_CURSOR, 63'd0);
      write_csr(CSR_PRIME_COUNT, 63'd6);
      for (int i = 0; i < 6; i++) send_item(FUNC_LOAD, 12'(i), 32'h0, 12'h0);
      send_item(FUNC_SIEVE, 12'h0, 32'h0, 12'h0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd1);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd2);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd4094);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd4095);
      drain();
   endtask

   // Real strikes across two consecutive segments.
   task automatic test_strikes();
      write_csr(CSR_PRIME_COUNT, 63'd4);
      send_item(FUNC_LOAD, 12'd0, 32'd31, 12'h0);
      send_item(FUNC_LOAD, 12'd1, 32'd37, 12'h0);
      send_item(FUNC_LOAD, 12'd2, 32'd1009, 12'h0);
      send_item(FUNC_LOAD, 12'd3, 32'hFFFF_FFFF, 12'h0);
      send_item(FUNC_LOAD, 12'd4, 32'd1, 12'h0);
      drain();
      send_item(FUNC_SIEVE, 12'h0, 32'h0, 12'h0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd100);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd4094);
      send_item(FUNC_SIEVE, 12'h0, 32'h0, 12'h0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd0);
      drain();
   endtask

   // Cursor rewrites: strikes left behind, wrap of the cursor and the largest cursor.
   task automatic test_cursor_rewrite();
      write_csr(CSR_START_CURSOR, 63'h4000_0000_0000_0000);
      send_item(FUNC_SIEVE, 12'h0, 32'h0, 12'h0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd7);
      drain();
      write_csr(CSR_START_CURSOR, 63'h7FFF_FFFF_FFFF_FFFF - 63'(SEG_BITS) + 63'd1);
      send_item(FUNC_LOAD, 12'd2, 32'd1009, 12'h0);
      send_item(FUNC_SIEVE, 12'h0, 32'h0, 12'h0);
      send_item(FUNC_LOAD, 12'd0, 32'd2003, 12'h0);
      send_item(FUNC_LOAD, 12'd1, 32'd4001, 12'h0);
      send_item(FUNC_SIEVE, 12'h0, 32'h0, 12'h0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd0);
      drain();
      write_csr(CSR_START_CURSOR, 63'h7FFF_FFFF_FFFF_FFFF);
      write_csr(CSR_PRIME_COUNT, 63'd0);
      send_item(FUNC_LOAD, 12'd3, 32'h8000_0001, 12'h0);
      send_item(FUNC_SIEVE, 12'h0, 32'h0, 12'h0);
      send_item(FUNC_READ, 12'h0, 32'h0, 12'd3);
      drain();
   endtask

   // Receiver holds off while the sender keeps offering items.
   task automatic test_backpressure();
      hold_req = 600;
      for (int i = 0; i < 10; i++) begin
         send_item(FUNC_READ, 12'h0, 32'h0, 12'($urandom_range(0, 4095)));
      end
      drain();
   endtask

   // Random mix of loads, reads, sieves and unknown functions, in phases.
   task automatic test_random();
      int          r;
      logic [11:0] slot;
      logic [31:0] value;
      logic [62:0] cur;
      for (int ph = 0; ph < 4; ph++) begin
         drain();
         r = $urandom_range(0, 2);
         if (r == 0) cur = 63'({$urandom, $urandom});
         else if (r == 1) cur = 63'(SEG_BITS) * 63'($urandom_range(0, 1000));
         else cur = 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 3 * SEG_BITS));
         write_csr(CSR_START_CURSOR, cur);
         write_csr(CSR_PRIME_COUNT, 63'($urandom_range(0, 8)));
         stall_pct = (ph == 0) ? 0 : 20 * ph;
         gaps_on   = (ph != 0);
         // Slots that a sieve scans hold primes large enough to keep strikes few.
         for (int i = 0; i < 8; i++) send_item(FUNC_LOAD, 12'(i), $urandom | 32'h400, 12'h0);
         for (int i = 0; i < 6; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
               if ($urandom_range(0, 1) == 0) begin
                  slot  = 12'($urandom_range(0, 7));
                  value = $urandom | 32'h400;
               end else begin
                  slot  = 12'($urandom_range(8, 4095));
                  value = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
               end
               send_item(FUNC_LOAD, slot, value, 12'($urandom));
            end else if (r < 85) begin
               send_item(FUNC_READ, 12'($urandom), $urandom, 12'($urandom_range(0, 4095)));
            end else if (r < 93) begin
               send_item(FUNC_SIEVE, 12'($urandom), $urandom, 12'($urandom));
            end else begin
               send_item(FUNC_BAD, 12'($urandom), $urandom, 12'($urandom));
            end
         end
      end
      drain();
   endtask

   initial begin
      cycle_count     = 0;
      error_count     = 0;
      items_sent      = 0;
      sieves_sent     = 0;
      results_checked = 0;
      stall_pct       = 10;
      hold_req        = 0;
      hold_cnt        = 0;
      burst_cnt       = 0;
      gaps_on         = 1;
      prime_count_q   = '0;
      cursor_now      = '0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= FUNC_LOAD;
      req_prime_index <= '0;
      req_prime_value <= '0;
      req_word_index  <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_START_CURSOR;
      csr_data        <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bad_items();
      test_table_fill();
      test_strikes();
      test_cursor_rewrite();
      test_backpressure();
      test_random();

      // Let the block settle after the last result.
      repeat (20) @(posedge clock);
      $display("Sent %0d items including %0d sieves; %0d results checked.", items_sent,
               sieves_sent, results_checked);
      $display("Covered zero primes, strikes, cursor rewrite and wrap, and backpressure.");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
